// ----- hw/rtl/dbc_pkg.sv -----
// Shared types and constants for the DDS-referenced compensator.
// Holds the control-word layout, the sequencer program, the sine table and
// the coefficient helpers used by the top level and the datapath.
`default_nettype none

package dbc_pkg;

  // Field widths
  localparam int unsigned ADC_W    = 10;
  localparam int unsigned DAC_W    = 12;
  localparam int unsigned ERR_W    = 13;
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned COEF_W   = 12;
  localparam int unsigned COEFS_W  = 60;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned PROD_W   = COEF_W + ERR_W;
  localparam int unsigned TBL_AW   = 8;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DAC_W-1:0] DAC_MAX = 12'd4095;

  // y = floor(adc * 129 / 40) == (adc * Y_RECIP) >> Y_SHIFT for every 10-bit adc
  localparam int unsigned      Y_SHIFT = 20;
  localparam logic [21:0]      Y_RECIP = 22'd3381658;
  localparam logic [DAC_W-1:0] SINE_OFFSET = 12'd1023;

  // Configuration reset values
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 16'd1267;
  localparam logic [1:0]         WAVE_MODE_RST  = 2'd0;
  localparam logic [DAC_W-1:0]   REF_HIGH_RST   = 12'd999;
  localparam logic [COEFS_W-1:0] COEFS_RST      = 60'h000_0000_0100_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 3'd0,
    CFG_WAVE_MODE  = 3'd1,
    CFG_REF_HIGH   = 3'd2,
    CFG_LAW_COEFS  = 3'd3,
    CFG_AWU_COEFS  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SQUARE   = 2'd2
  } wave_t;

  // Sequencer control word
  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_TAKE = 3'd1,  // wait for and latch a request
    ACT_ERR  = 3'd2,  // form reference and error
    ACT_EMIT = 3'd3,  // load result, shift histories, advance phase
    ACT_LAWP = 3'd4,  // store MAC sum as normal-law partial
    ACT_AWUP = 3'd5   // store MAC sum as anti-windup partial
  } act_t;

  typedef enum logic [1:0] {
    BASE_ZERO = 2'd0,
    BASE_ACC  = 2'd1,
    BASE_LAWP = 2'd2,
    BASE_AWUP = 2'd3
  } base_t;

  typedef enum logic {
    BANK_LAW = 1'b0,
    BANK_AWU = 1'b1
  } bank_t;

  typedef enum logic [2:0] {
    COEF_A1 = 3'd0,
    COEF_A2 = 3'd1,
    COEF_B0 = 3'd2,
    COEF_B1 = 3'd3,
    COEF_B2 = 3'd4
  } coef_t;

  typedef enum logic [2:0] {
    OPD_E  = 3'd0,
    OPD_E1 = 3'd1,
    OPD_E2 = 3'd2,
    OPD_U1 = 3'd3,
    OPD_U2 = 3'd4
  } opd_t;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_IN_RANGE = 2'd1,
    JMP_ALWAYS   = 2'd2
  } jmp_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    act_t  act;
    base_t base;
    bank_t bank;
    coef_t coef;
    opd_t  opd;
    logic  neg;
    logic  acc_we;
    jmp_t  jmp;
    step_t target;
  } ctrl_word_t;

  localparam step_t STEP_TAKE = 4'd0;
  localparam step_t STEP_EMIT = 4'd5;

  // Program ROM. Field order: act, base, bank, coef, opd, neg, acc_we, jmp, target
  function automatic ctrl_word_t prog_word(input step_t s);
    ctrl_word_t w;
    unique case (s)
      4'd0:  w = '{ACT_TAKE, BASE_ZERO, BANK_LAW, COEF_B0, OPD_E,  1'b0, 1'b0,
                  JMP_NEXT, STEP_TAKE};
      4'd1:  w = '{ACT_ERR,  BASE_ZERO, BANK_LAW, COEF_B0, OPD_E,  1'b0, 1'b0,
                  JMP_NEXT, STEP_TAKE};
      4'd2:  w = '{ACT_NONE, BASE_LAWP, BANK_LAW, COEF_B0, OPD_E,  1'b0, 1'b1,
                  JMP_NEXT, STEP_TAKE};
      4'd3:  w = '{ACT_NONE, BASE_ZERO, BANK_LAW, COEF_B0, OPD_E,  1'b0, 1'b0,
                  JMP_IN_RANGE, STEP_EMIT};
      4'd4:  w = '{ACT_NONE, BASE_AWUP, BANK_AWU, COEF_B0, OPD_E,  1'b0, 1'b1,
                  JMP_NEXT, STEP_TAKE};
      4'd5:  w = '{ACT_EMIT, BASE_ZERO, BANK_LAW, COEF_B0, OPD_E,  1'b0, 1'b0,
                  JMP_NEXT, STEP_TAKE};
      4'd6:  w = '{ACT_NONE, BASE_ZERO, BANK_LAW, COEF_A1, OPD_U1, 1'b1, 1'b1,
                  JMP_NEXT, STEP_TAKE};
      4'd7:  w = '{ACT_NONE, BASE_ACC,  BANK_LAW, COEF_A2, OPD_U2, 1'b1, 1'b1,
                  JMP_NEXT, STEP_TAKE};
      4'd8:  w = '{ACT_NONE, BASE_ACC,  BANK_LAW, COEF_B1, OPD_E1, 1'b0, 1'b1,
                  JMP_NEXT, STEP_TAKE};
      4'd9:  w = '{ACT_LAWP, BASE_ACC,  BANK_LAW, COEF_B2, OPD_E2, 1'b0, 1'b0,
                  JMP_NEXT, STEP_TAKE};
      4'd10: w = '{ACT_NONE, BASE_ZERO, BANK_AWU, COEF_A1, OPD_U1, 1'b1, 1'b1,
                  JMP_NEXT, STEP_TAKE};
      4'd11: w = '{ACT_NONE, BASE_ACC,  BANK_AWU, COEF_A2, OPD_U2, 1'b1, 1'b1,
                  JMP_NEXT, STEP_TAKE};
      4'd12: w = '{ACT_NONE, BASE_ACC,  BANK_AWU, COEF_B1, OPD_E1, 1'b0, 1'b1,
                  JMP_NEXT, STEP_TAKE};
      4'd13: w = '{ACT_AWUP, BASE_ACC,  BANK_AWU, COEF_B2, OPD_E2, 1'b0, 1'b0,
                  JMP_ALWAYS, STEP_TAKE};
      default: w = '{ACT_NONE, BASE_ZERO, BANK_LAW, COEF_B0, OPD_E, 1'b0, 1'b0,
                  JMP_ALWAYS, STEP_TAKE};
    endcase
    return w;
  endfunction

  // Signed 12-bit field of a packed coefficient register
  function automatic logic signed [COEF_W-1:0] coef_field(input logic [COEFS_W-1:0] regv,
                                                          input coef_t k);
    logic signed [COEF_W-1:0] c;
    unique case (k)
      COEF_A1: c = $signed(regv[11:0]);
      COEF_A2: c = $signed(regv[23:12]);
      COEF_B0: c = $signed(regv[35:24]);
      COEF_B1: c = $signed(regv[47:36]);
      COEF_B2: c = $signed(regv[59:48]);
      default: c = '0;
    endcase
    return c;
  endfunction

  // Triangle: rises by 2 up to 0xff, then falls by 2 to 0
  function automatic logic [7:0] tri_entry(input logic [TBL_AW-1:0] i);
    logic [7:0] d;
    logic [7:0] t;
    d = {1'b0, i[5:0], 1'b0};
    case (i[7:6])
      2'd0: t = d + 8'h02;
      2'd1: t = 8'h81 + d;
      2'd2: t = (i[5:0] == 6'h3f) ? 8'h80 : 8'hfd - d;
      default: t = 8'h7e - d;
    endcase
    return t;
  endfunction

  localparam logic [7:0] SINE_ROM [256] = '{
    8'h80, 8'h83, 8'h86, 8'h89, 8'h8c, 8'h8f, 8'h92, 8'h95,
    8'h98, 8'h9b, 8'h9e, 8'ha2, 8'ha5, 8'ha7, 8'haa, 8'had,
    8'hb0, 8'hb3, 8'hb6, 8'hb9, 8'hbc, 8'hbe, 8'hc1, 8'hc4,
    8'hc6, 8'hc9, 8'hcb, 8'hce, 8'hd0, 8'hd3, 8'hd5, 8'hd7,
    8'hda, 8'hdc, 8'hde, 8'he0, 8'he2, 8'he4, 8'he6, 8'he8,
    8'hea, 8'heb, 8'hed, 8'hee, 8'hf0, 8'hf1, 8'hf3, 8'hf4,
    8'hf5, 8'hf6, 8'hf8, 8'hf9, 8'hfa, 8'hfa, 8'hfb, 8'hfc,
    8'hfd, 8'hfd, 8'hfe, 8'hfe, 8'hfe, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 8'hfe, 8'hfe, 8'hfd,
    8'hfd, 8'hfc, 8'hfb, 8'hfa, 8'hfa, 8'hf9, 8'hf8, 8'hf6,
    8'hf5, 8'hf4, 8'hf3, 8'hf1, 8'hf0, 8'hee, 8'hed, 8'heb,
    8'hea, 8'he8, 8'he6, 8'he4, 8'he2, 8'he0, 8'hde, 8'hdc,
    8'hda, 8'hd7, 8'hd5, 8'hd3, 8'hd0, 8'hce, 8'hcb, 8'hc9,
    8'hc6, 8'hc4, 8'hc1, 8'hbe, 8'hbc, 8'hb9, 8'hb6, 8'hb3,
    8'hb0, 8'had, 8'haa, 8'ha7, 8'ha5, 8'ha2, 8'h9e, 8'h9b,
    8'h98, 8'h95, 8'h92, 8'h8f, 8'h8c, 8'h89, 8'h86, 8'h83,
    8'h80, 8'h7c, 8'h79, 8'h76, 8'h73, 8'h70, 8'h6d, 8'h6a,
    8'h67, 8'h64, 8'h61, 8'h5d, 8'h5a, 8'h58, 8'h55, 8'h52,
    8'h4f, 8'h4c, 8'h49, 8'h46, 8'h43, 8'h41, 8'h3e, 8'h3b,
    8'h39, 8'h36, 8'h34, 8'h31, 8'h2f, 8'h2c, 8'h2a, 8'h28,
    8'h25, 8'h23, 8'h21, 8'h1f, 8'h1d, 8'h1b, 8'h19, 8'h17,
    8'h15, 8'h14, 8'h12, 8'h11, 8'h0f, 8'h0e, 8'h0c, 8'h0b,
    8'h0a, 8'h09, 8'h07, 8'h06, 8'h05, 8'h05, 8'h04, 8'h03,
    8'h02, 8'h02, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h02,
    8'h02, 8'h03, 8'h04, 8'h05, 8'h05, 8'h06, 8'h07, 8'h09,
    8'h0a, 8'h0b, 8'h0c, 8'h0e, 8'h0f, 8'h11, 8'h12, 8'h14,
    8'h15, 8'h17, 8'h19, 8'h1b, 8'h1d, 8'h1f, 8'h21, 8'h23,
    8'h25, 8'h28, 8'h2a, 8'h2c, 8'h2f, 8'h31, 8'h34, 8'h36,
    8'h39, 8'h3b, 8'h3e, 8'h41, 8'h43, 8'h46, 8'h49, 8'h4c,
    8'h4f, 8'h52, 8'h55, 8'h58, 8'h5a, 8'h5d, 8'h61, 8'h64,
    8'h67, 8'h6a, 8'h6d, 8'h70, 8'h73, 8'h76, 8'h79, 8'h7c
  };

endpackage

`default_nettype wire

// ----- hw/rtl/dbc_datapath.sv -----
// Datapath of the compensator: reference generator, error, one shared
// multiply-accumulate unit, histories and precomputed partial sums.
// Driven step by step by the control word from the top level; uses dbc_pkg.
`default_nettype none

module dbc_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire dbc_pkg::ctrl_word_t             ctrl,
  input  wire logic                            go,
  input  wire logic [dbc_pkg::ADC_W-1:0]       adc_sample,
  input  wire logic [dbc_pkg::PHASE_W-1:0]     phase_step,
  input  wire logic [1:0]                      wave_mode,
  input  wire logic [dbc_pkg::DAC_W-1:0]       ref_high,
  input  wire logic [dbc_pkg::COEFS_W-1:0]     law_coefs,
  input  wire logic [dbc_pkg::COEFS_W-1:0]     awu_coefs,
  output logic                                 in_range,
  output logic [dbc_pkg::DAC_W-1:0]            drive,
  output logic signed [dbc_pkg::ERR_W-1:0]     err,
  output logic [dbc_pkg::DAC_W-1:0]            ref_level
);
  import dbc_pkg::*;

  logic [ADC_W-1:0]          adc_r;
  logic [PHASE_W-1:0]        phase_r;
  logic signed [ERR_W-1:0]   e_r, e1_r, e2_r;
  logic [DAC_W-1:0]          u1_r, u2_r;
  logic [DAC_W-1:0]          ref_r;
  logic signed [ACC_W-1:0]   acc_r, lawp_r, awup_r;

  logic [31:0]               y_prod;
  logic [DAC_W-1:0]          y_val;
  logic [TBL_AW-1:0]         tbl_idx;
  logic [7:0]                tbl_val;
  logic [14:0]               tbl_scaled;
  logic [DAC_W-1:0]          ref_val;
  logic signed [ERR_W-1:0]   e_val;

  logic signed [COEF_W-1:0]  mul_c;
  logic signed [ERR_W-1:0]   mul_d;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   base_val;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   sum;

  // Measurement scaling and reference
  assign y_prod  = 32'(adc_r) * 32'(Y_RECIP);
  assign y_val   = y_prod[Y_SHIFT +: DAC_W];
  assign tbl_idx = phase_r[PHASE_W-1 -: TBL_AW];

  always_comb begin
    if (wave_mode == WAVE_SINE) begin
      tbl_val = SINE_ROM[tbl_idx];
    end else begin
      tbl_val = tri_entry(tbl_idx);
    end
    tbl_scaled = 15'(tbl_val) * 15'd125;
    case (wave_mode)
      WAVE_SINE:     ref_val = DAC_W'(tbl_scaled >> 5) + SINE_OFFSET;
      WAVE_TRIANGLE: ref_val = DAC_W'(tbl_scaled >> 5);
      // unused mode behaves as the square wave
      default:       ref_val = phase_r[PHASE_W-1] ? ref_high : '0;
    endcase
    e_val = $signed({1'b0, ref_val}) - $signed({1'b0, y_val});
  end

  // Shared multiply-accumulate
  always_comb begin
    mul_c = (ctrl.bank == BANK_AWU) ? coef_field(awu_coefs, ctrl.coef)
                                    : coef_field(law_coefs, ctrl.coef);
    case (ctrl.opd)
      OPD_E:   mul_d = e_r;
      OPD_E1:  mul_d = e1_r;
      OPD_E2:  mul_d = e2_r;
      OPD_U1:  mul_d = $signed({1'b0, u1_r});
      OPD_U2:  mul_d = $signed({1'b0, u2_r});
      default: mul_d = '0;
    endcase
    prod = PROD_W'(mul_c) * PROD_W'(mul_d);
    case (ctrl.base)
      BASE_ZERO: base_val = '0;
      BASE_ACC:  base_val = acc_r;
      BASE_LAWP: base_val = lawp_r;
      default:   base_val = awup_r;
    endcase
    term = ctrl.neg ? -ACC_W'(prod) : ACC_W'(prod);
    sum  = base_val + term;
  end

  assign in_range = !acc_r[ACC_W-1] && (acc_r[ACC_W-2:DAC_W] == '0);

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      drive = '0;
    end else if (acc_r[ACC_W-2:DAC_W] != '0) begin
      drive = DAC_MAX;
    end else begin
      drive = acc_r[DAC_W-1:0];
    end
  end

  assign err       = e_r;
  assign ref_level = ref_r;

  // Payload registers
  always_ff @(posedge clk) begin
    if (go && ctrl.act == ACT_TAKE) begin
      adc_r <= adc_sample;
    end
    if (go && ctrl.act == ACT_ERR) begin
      e_r   <= e_val;
      ref_r <= ref_val;
    end
    if (go && ctrl.acc_we) begin
      acc_r <= sum;
    end
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      e1_r    <= '0;
      e2_r    <= '0;
      u1_r    <= '0;
      u2_r    <= '0;
      lawp_r  <= '0;
      awup_r  <= '0;
    end else if (go) begin
      if (ctrl.act == ACT_EMIT) begin
        e2_r    <= e1_r;
        e1_r    <= e_r;
        u2_r    <= u1_r;
        u1_r    <= drive;
        phase_r <= phase_r + phase_step;
      end
      if (ctrl.act == ACT_LAWP) begin
        lawp_r <= sum;
      end
      if (ctrl.act == ACT_AWUP) begin
        awup_r <= sum;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dds_reference_biquad_controller.sv -----
// Top level of the DDS-referenced second-order compensator with anti-windup.
// Holds configuration, the program sequencer and the result register;
// instantiates dbc_datapath and uses dbc_pkg.
//
// Usage:
//   Input channel in_valid/in_stall carries one 10-bit converter sample per
//   request. Result channel out_valid/out_stall carries drive, error and
//   reference for that sample. Configuration is a plain write port
//   (cfg_wr_en, cfg_index, cfg_wdata); write it only while the block is idle.
//   A 14-step microprogram runs one shared 12x13 multiplier: error, drive
//   (one extra step when anti-windup applies), emit, then four MAC steps for
//   each partial sum. The result is loaded into the output register at the
//   emit step; the next request is taken only after the program has run
//   both partial sums and returned to the take step. The step count of the
//   program, one multiply per step, sets how often requests are taken.
//   The result sits in an output register; the sequencer holds at the emit
//   step while the previous result is still stalled, and in_stall stays
//   high whenever the sequencer is not waiting for a request.
//   Synchronous reset clears phase, histories and partial sums, loads the
//   default configuration and drops out_valid.
`default_nettype none

module dds_reference_biquad_controller (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [dbc_pkg::ADC_W-1:0]             in_adc_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [dbc_pkg::DAC_W-1:0]                  out_drive_value,
  output logic signed [dbc_pkg::ERR_W-1:0]           out_error_value,
  output logic [dbc_pkg::DAC_W-1:0]                  out_reference_value,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [dbc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [dbc_pkg::COEFS_W-1:0]           cfg_wdata
);
  import dbc_pkg::*;

  logic [PHASE_W-1:0]       phase_step_r;
  logic [1:0]               wave_mode_r;
  logic [DAC_W-1:0]         ref_high_r;
  logic [COEFS_W-1:0]       law_coefs_r;
  logic [COEFS_W-1:0]       awu_coefs_r;

  step_t                    step_r, step_nxt;
  ctrl_word_t               ctrl;
  logic                     hold;
  logic                     go;
  logic                     in_range;

  logic [DAC_W-1:0]         dp_drive;
  logic signed [ERR_W-1:0]  dp_err;
  logic [DAC_W-1:0]         dp_ref;

  logic                     out_valid_r;
  logic [DAC_W-1:0]         out_drive_r;
  logic signed [ERR_W-1:0]  out_err_r;
  logic [DAC_W-1:0]         out_ref_r;
  logic                     emit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      wave_mode_r  <= WAVE_MODE_RST;
      ref_high_r   <= REF_HIGH_RST;
      law_coefs_r  <= COEFS_RST;
      awu_coefs_r  <= COEFS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PHASE_STEP: phase_step_r <= cfg_wdata[PHASE_W-1:0];
        CFG_WAVE_MODE:  wave_mode_r  <= cfg_wdata[1:0];
        CFG_REF_HIGH:   ref_high_r   <= cfg_wdata[DAC_W-1:0];
        CFG_LAW_COEFS:  law_coefs_r  <= cfg_wdata;
        CFG_AWU_COEFS:  awu_coefs_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  assign ctrl = prog_word(step_r);

  always_comb begin
    case (ctrl.act)
      ACT_TAKE: hold = !in_valid;
      ACT_EMIT: hold = out_valid_r && out_stall;
      default:  hold = 1'b0;
    endcase
    go = !hold;

    step_nxt = step_r + 1'b1;
    if (hold) begin
      step_nxt = step_r;
    end else begin
      case (ctrl.jmp)
        JMP_IN_RANGE: if (in_range) step_nxt = ctrl.target;
        JMP_ALWAYS:   step_nxt = ctrl.target;
        default:      step_nxt = step_r + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_TAKE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_stall = (ctrl.act != ACT_TAKE);

  dbc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .go         (go),
    .adc_sample (in_adc_sample),
    .phase_step (phase_step_r),
    .wave_mode  (wave_mode_r),
    .ref_high   (ref_high_r),
    .law_coefs  (law_coefs_r),
    .awu_coefs  (awu_coefs_r),
    .in_range   (in_range),
    .drive      (dp_drive),
    .err        (dp_err),
    .ref_level  (dp_ref)
  );

  // Result register
  assign emit = go && (ctrl.act == ACT_EMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_drive_r <= dp_drive;
      out_err_r   <= dp_err;
      out_ref_r   <= dp_ref;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_value     = out_drive_r;
  assign out_error_value     = out_err_r;
  assign out_reference_value = out_ref_r;

endmodule

`default_nettype wire

// ----- bench/tb_dds_reference_biquad_controller.sv -----
`timescale 1ns / 1ps
// Self-checking bench for dds_reference_biquad_controller: drives ADC samples and
// register settings, predicts drive, error and reference per tick. Needs dbc_pkg.

module tb_dds_reference_biquad_controller;
  import dbc_pkg::*;

  localparam int     CLK_PERIOD    = 10;
  localparam int     CYCLE_LIMIT   = 600000;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     MAX_GAP       = 20;
  localparam int     RAND_PHASES   = 24;
  localparam int     PHASE_ITEMS   = 64;
  localparam longint DRIVE_CEIL    = DAC_MAX;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;
  localparam logic [1:0]           WAVE_SPARE    = 2'd3;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [ADC_W-1:0]         in_adc_sample;
  logic                     out_valid;
  logic                     out_stall;
  logic [DAC_W-1:0]         out_drive_value;
  logic signed [ERR_W-1:0]  out_error_value;
  logic [DAC_W-1:0]         out_reference_value;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [COEFS_W-1:0]       cfg_wdata;

  int src_idle_pct;
  int sink_idle_pct;
  bit sink_hold_req;
  int cycles;
  int settings_applied;

  dds_reference_biquad_controller u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_adc_sample       (in_adc_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_drive_value     (out_drive_value),
    .out_error_value     (out_error_value),
    .out_reference_value (out_reference_value),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // Shadow of the compensator: registers, histories and the ticks still owed.
  class compensator_shadow;
    typedef struct {
      logic [DAC_W-1:0]        drive;
      logic signed [ERR_W-1:0] err;
      logic [DAC_W-1:0]        level;
    } tick_t;

    tick_t              pending_ticks[$];
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] step;
    logic [1:0]         mode;
    logic [DAC_W-1:0]   level_high;
    logic [COEFS_W-1:0] law;
    logic [COEFS_W-1:0] awu;
    longint             e1, e2, u1, u2, law_part, awu_part;
    int                 errors, checked, awu_hits, clamps;

    function new();
      phase = '0;
      step = PHASE_STEP_RST;
      mode = WAVE_MODE_RST;
      level_high = REF_HIGH_RST;
      law = COEFS_RST;
      awu = COEFS_RST;
      e1 = 0; e2 = 0; u1 = 0; u2 = 0;
      law_part = 0; awu_part = 0;
      errors = 0; checked = 0; awu_hits = 0; clamps = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEFS_W-1:0] data);
      case (idx)
        CFG_PHASE_STEP: step = data[PHASE_W-1:0];
        CFG_WAVE_MODE:  mode = data[1:0];
        CFG_REF_HIGH:   level_high = data[DAC_W-1:0];
        CFG_LAW_COEFS:  law = data;
        CFG_AWU_COEFS:  awu = data;
        default: ;  // unused index: drop
      endcase
    endfunction

    function longint coef_at(logic [COEFS_W-1:0] bank, coef_t k);
      logic signed [COEF_W-1:0] c;
      c = bank[COEF_W*k +: COEF_W];
      return c;
    endfunction

    function longint partial_of(logic [COEFS_W-1:0] bank);
      return -coef_at(bank, COEF_A1) * u1 - coef_at(bank, COEF_A2) * u2
             + coef_at(bank, COEF_B1) * e1 + coef_at(bank, COEF_B2) * e2;
    endfunction

    // Triangle table: up by 2 to the top, then down by 2.
    function longint tri_level(int i);
      if (i < 64) return 2 * i + 2;
      if (i < 128) return 129 + 2 * (i - 64);
      if (i < 191) return 253 - 2 * (i - 128);
      if (i == 191) return 128;
      return 126 - 2 * (i - 192);
    endfunction

    function void take_sample(logic [ADC_W-1:0] adc);
      longint y, r, e, v;
      int     idx;
      tick_t  t;
      y = (longint'(adc) * 129) / 40;
      idx = phase[PHASE_W-1 -: TBL_AW];
      case (mode)
        WAVE_SINE:     r = (longint'(SINE_ROM[idx]) * 125) / 32 + 1023;
        WAVE_TRIANGLE: r = (tri_level(idx) * 125) / 32;
        default:       r = phase[PHASE_W-1] ? longint'(level_high) : 0;
      endcase
      e = r - y;
      v = law_part + coef_at(law, COEF_B0) * e;
      if (v < 0 || v > DRIVE_CEIL) begin
        awu_hits++;
        v = awu_part + coef_at(awu, COEF_B0) * e;
        if (v > DRIVE_CEIL) begin
          v = DRIVE_CEIL;
          clamps++;
        end else if (v < 0) begin
          v = 0;
          clamps++;
        end
      end
      t.drive = v[DAC_W-1:0];
      t.err = e[ERR_W-1:0];
      t.level = r[DAC_W-1:0];
      pending_ticks.push_back(t);
      e2 = e1; e1 = e;
      u2 = u1; u1 = v;
      law_part = partial_of(law);
      awu_part = partial_of(awu);
      phase = phase + step;
    endfunction

    function void match_result(logic [DAC_W-1:0] drive, logic signed [ERR_W-1:0] err,
                               logic [DAC_W-1:0] level);
      tick_t want;
      if (pending_ticks.size() == 0) begin
        $display("%0t: unexpected result: drive %0d error %0d reference %0d",
                 $time, drive, err, level);
        errors++;
        return;
      end
      want = pending_ticks.pop_front();
      checked++;
      if (drive !== want.drive) begin
        $display("%0t: drive_value expected %0d, actual %0d", $time, want.drive, drive);
        errors++;
      end
      if (err !== want.err) begin
        $display("%0t: error_value expected %0d, actual %0d", $time, want.err, err);
        errors++;
      end
      if (level !== want.level) begin
        $display("%0t: reference_value expected %0d, actual %0d", $time, want.level, level);
        errors++;
      end
    endfunction
  endclass

  compensator_shadow shadow;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result side: check on accept, then pick the next stall value.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0)
        shadow.match_result(out_drive_value, out_error_value, out_reference_value);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  function automatic logic [COEFS_W-1:0] noise60();
    logic [63:0] n;
    n = {$urandom, $urandom};
    return n[COEFS_W-1:0];
  endfunction

  function automatic logic [COEFS_W-1:0] pack_coefs(logic [COEF_W-1:0] a1, logic [COEF_W-1:0] a2,
                                                    logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                                                    logic [COEF_W-1:0] b2);
    return {b2, b1, b0, a2, a1};
  endfunction

  function automatic logic [COEFS_W-1:0] pick_coefs();
    logic [COEF_W-1:0] f[5];
    case ($urandom_range(3))
      0: foreach (f[i]) f[i] = COEF_W'($urandom_range(16) - 8);
      1: foreach (f[i]) f[i] = COEF_W'($urandom);
      2: foreach (f[i]) f[i] = $urandom_range(1) ? 12'h7ff : 12'h800;
      default: begin
        // integrator: u = u1 + b0*e
        f[0] = 12'hfff;
        f[1] = '0;
        f[2] = COEF_W'($urandom_range(3));
        f[3] = '0;
        f[4] = '0;
      end
    endcase
    return pack_coefs(f[0], f[1], f[2], f[3], f[4]);
  endfunction

  function automatic logic [ADC_W-1:0] pick_adc();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return ADC_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEFS_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    shadow.write_reg(idx, data);
  endtask

  // Junk in the upper bits of narrow registers must be dropped by the block.
  task automatic apply_settings(logic [PHASE_W-1:0] step, logic [1:0] mode,
                                logic [DAC_W-1:0] high, logic [COEFS_W-1:0] law,
                                logic [COEFS_W-1:0] awu);
    logic [COEFS_W-1:0] n;
    write_reg(CFG_IDX_SPARE + CFG_IDX_W'($urandom_range(2)), noise60());
    n = noise60();
    n[PHASE_W-1:0] = step;
    write_reg(CFG_PHASE_STEP, n);
    n = noise60();
    n[1:0] = mode;
    write_reg(CFG_WAVE_MODE, n);
    n = noise60();
    n[DAC_W-1:0] = high;
    write_reg(CFG_REF_HIGH, n);
    write_reg(CFG_LAW_COEFS, law);
    write_reg(CFG_AWU_COEFS, awu);
    cfg_wr_en <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_sample(logic [ADC_W-1:0] s);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_sample <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    shadow.take_sample(s);
  endtask

  task automatic drain();
    while (shadow.pending_ticks.size() != 0) @(posedge clk);
  endtask

  // Drop the request line, collect every result, let the partial sums finish.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_batch(int count, int hold_at, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) sink_hold_req = 1'b1;
      if (i == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        drain();
      end
      send_sample(pick_adc());
    end
  endtask

  initial begin
    logic [ADC_W-1:0] corner_adc[4];
    logic [PHASE_W-1:0] step;
    logic [DAC_W-1:0]   high;
    corner_adc = '{10'h000, 10'h3ff, 10'h155, 10'h2aa};
    shadow = new();
    settings_applied = 0;
    sink_hold_req = 1'b0;
    src_idle_pct = 35;
    sink_idle_pct = 64;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_adc_sample = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: sine, proportional law, negative errors clamp to zero.
    foreach (corner_adc[i]) send_sample(corner_adc[i]);
    send_sample(10'd1);
    send_sample(10'd1022);
    quiesce();

    apply_settings(16'h1f00, WAVE_TRIANGLE, 12'd2048,
                   pack_coefs(12'hfff, 12'h000, 12'h001, 12'h000, 12'h000),
                   pack_coefs(12'hfff, 12'h000, 12'h000, 12'h000, 12'h000));
    foreach (corner_adc[i]) send_sample(corner_adc[i]);
    send_sample(pick_adc());
    quiesce();

    apply_settings(16'h8000, WAVE_SQUARE, 12'd4095,
                   pack_coefs(12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff),
                   pack_coefs(12'h800, 12'h800, 12'h800, 12'h800, 12'h800));
    foreach (corner_adc[i]) send_sample(corner_adc[i]);
    send_sample(pick_adc());
    quiesce();

    // Spare wave code acts as square; full-scale step wraps the phase.
    apply_settings(16'hffff, WAVE_SPARE, 12'd0,
                   pack_coefs(12'h800, 12'h800, 12'h800, 12'h800, 12'h800),
                   pack_coefs(12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff));
    foreach (corner_adc[i]) send_sample(corner_adc[i]);
    send_sample(pick_adc());
    quiesce();

    apply_settings(16'h0000, WAVE_SINE, DAC_W'($urandom), '0, '0);
    foreach (corner_adc[i]) send_sample(corner_adc[i]);
    quiesce();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < RAND_PHASES / 3) begin
        src_idle_pct = 35;
        sink_idle_pct = 64;
      end else if (p < 2 * RAND_PHASES / 3) begin
        src_idle_pct = 64;
        sink_idle_pct = 35;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      case ($urandom_range(3))
        0: step = '0;
        1: step = '1;
        2: step = PHASE_W'($urandom_range(600, 1));
        default: step = PHASE_W'($urandom);
      endcase
      case ($urandom_range(2))
        0: high = '0;
        1: high = DAC_MAX;
        default: high = DAC_W'($urandom);
      endcase
      apply_settings(step, 2'($urandom_range(3)), high, pick_coefs(), pick_coefs());
      run_batch(PHASE_ITEMS, (p == 2 || p == 18) ? 10 : -1, (p == 5) ? 30 : -1);
      quiesce();
    end

    $display("Checked %0d ticks across %0d register settings, all wave codes included.",
             shadow.checked, settings_applied + 1);
    $display("Anti-windup path taken %0d times, drive clamped %0d times.",
             shadow.awu_hits, shadow.clamps);
    if (shadow.errors == 0 && shadow.pending_ticks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dbc_pkg.sv
hw/rtl/dbc_datapath.sv
hw/rtl/dds_reference_biquad_controller.sv
bench/tb_dds_reference_biquad_controller.sv
